>>> design/bcsbp_pkg.sv
`timescale 1ns / 1ps
package bcsbp_pkg;
  localparam int TimeW = 63;
  localparam int WideW = 64;
  localparam int PhaseW = 26;
  localparam int LatW = 9;
  localparam int WinW = 32;
  localparam int ChanW = 8;
  localparam int BpmW = 8;
  localparam int CfgW = 32;
  localparam logic [LatW-1:0] LatencyMax = LatW'(500);
  localparam logic [WinW-1:0] WindowReset = WinW'(5000000);
  localparam logic [WideW-1:0] PeriodNum = WideW'(60000000);
  localparam logic [9:0] UsPerMs = 10'd1000;

  typedef enum logic [0:0] {
    CFG_LATENCY = 1'b0,
    CFG_WINDOW  = 1'b1
  } cfg_idx_t;

  localparam logic OP_BEACON = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [TimeW-1:0]     local_time_us;
    logic [TimeW-1:0]     sender_time_us;
    logic [TimeW-1:0]     anchor_time_us;
    logic [ChanW-1:0]     channel;
    logic [BpmW-1:0]      tempo_bpm;
  } in_word_t;

  typedef struct packed {
    logic                    synced;
    logic signed [WideW-1:0] offset_estimate_us;
    logic [PhaseW-1:0]       since_beat_us;
    logic [TimeW-1:0]        beat_count;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [WideW-1:0] dividend;
    logic [WideW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WideW-1:0] quot;
    logic [WideW-1:0] rem;
  } div_rsp_t;
endpackage

>>> design/bcsbp_if.sv
`timescale 1ns / 1ps
interface bcsbp_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/bcsbp_div.sv
`timescale 1ns / 1ps
module bcsbp_div import bcsbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [WideW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [WideW:0] trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[WideW-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend; r_nxt = '0; d_nxt = req.divisor;
      cnt_nxt = 7'(WideW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[WideW]) begin
        r_nxt = trial[WideW-1:0]; q_nxt = {q_r[WideW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[WideW-2:0], q_r[WideW-1]}; q_nxt = {q_r[WideW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign rsp = '{done: done_r, quot: q_r, rem: r_r};
endmodule

>>> design/beacon_clock_sync_beat_phase.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_     | in  | op, local/sender/anchor time, channel, tempo_bpm
// out_    | out | synced, offset_estimate_us, since_beat_us, beat_count
// cfg_    | in  | delay in ms (CFG_LATENCY), trailing window in us (CFG_WINDOW); write only
// One word at a time. A beacon first scans the ring; then, for every word, a bit-serial
// 64-bit divider computes the period and then the split into beats and phase.
// rst_n is synchronous; ring contents are not cleared, fill_r gates reads.
// A held result blocks new input until taken.
module beacon_clock_sync_beat_phase import bcsbp_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bcsbp_if.sink                 in_ch,
  bcsbp_if.source               out_ch,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CfgW-1:0]       cfg_wdata
);
  localparam int PW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_PER   = 7'b0000100,
    S_PWAIT = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_DWAIT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [LatW-1:0] lat_r;
  logic [WinW-1:0] win_r;
  logic have_ref_r, valid_r;
  logic [WideW-1:0] anchor_r, best_r, now_r, period_r, delta_r;
  logic [ChanW-1:0] chan_r;
  logic [BpmW-1:0] bpm_r;
  logic [FW-1:0] fill_r;
  logic [PW-1:0] wpos_r, scan_r;
  logic [WideW-1:0] ring_off [RING_DEPTH];
  logic [WideW-1:0] ring_arr [RING_DEPTH];
  logic [WideW-1:0] rd_off_r, rd_arr_r;
  logic rd_ok_r;
  logic [FW-1:0] scan_cnt_r;
  out_word_t res_r;
  div_req_t dreq;
  div_rsp_t drsp;

  in_word_t iw;
  assign iw = in_ch.data;
  assign in_ch.ready = state_r == S_IDLE;
  assign out_ch.valid = state_r == S_OUT;
  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '0; win_r <= WindowReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LATENCY: lat_r <= (cfg_wdata[LatW-1:0] > LatencyMax) ? LatencyMax
                                                                   : cfg_wdata[LatW-1:0];
        CFG_WINDOW:  win_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bcsbp_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  logic [WideW-1:0] age, est;
  logic [19:0] lat_us;
  logic in_win;
  assign age = now_r - rd_arr_r;
  assign in_win = age[WideW-1] || (age <= {32'd0, win_r});
  assign lat_us = 20'(lat_r) * 20'(UsPerMs);
  assign est = now_r - best_r - WideW'(lat_us) - anchor_r;

  always_comb begin
    state_nxt = state_r;
    dreq = '{start: 1'b0, dividend: PeriodNum,
             divisor: (bpm_r == '0) ? WideW'(1) : WideW'(bpm_r)};
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = (iw.op == OP_BEACON) ? S_SCAN : S_PER;
      S_SCAN:  if (scan_cnt_r == '0) state_nxt = S_PER;
      S_PER: begin
        dreq.start = 1'b1; state_nxt = S_PWAIT;
      end
      S_PWAIT: if (drsp.done) state_nxt = S_DIV;
      S_DIV: begin
        dreq.start = 1'b1;
        dreq.dividend = delta_r[WideW-1] ? (WideW'(0) - delta_r) : delta_r;
        dreq.divisor = period_r;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: if (drsp.done) state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; have_ref_r <= 1'b0; valid_r <= 1'b0; anchor_r <= '0;
      chan_r <= '0; bpm_r <= '0; best_r <= '0; fill_r <= '0; wpos_r <= '0;
      rd_ok_r <= 1'b0; scan_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      rd_ok_r <= 1'b0;
      if (state_r == S_IDLE && in_ch.valid) begin
        now_r <= {1'b0, iw.local_time_us};
        if (iw.op == OP_BEACON) begin
          logic fresh;
          fresh = !have_ref_r || {1'b0, iw.anchor_time_us} != anchor_r
                  || iw.channel != chan_r;
          have_ref_r <= 1'b1; valid_r <= 1'b1;
          anchor_r <= {1'b0, iw.anchor_time_us}; chan_r <= iw.channel;
          bpm_r <= iw.tempo_bpm;
          best_r <= {1'b0, iw.local_time_us} - {1'b0, iw.sender_time_us};
          ring_off[fresh ? '0 : wpos_r] <= {1'b0, iw.local_time_us}
                                          - {1'b0, iw.sender_time_us};
          ring_arr[fresh ? '0 : wpos_r] <= {1'b0, iw.local_time_us};
          wpos_r <= PW'((fresh ? 0 : int'(wpos_r)) + 1 == RING_DEPTH ? 0
                        : (fresh ? 0 : int'(wpos_r)) + 1);
          if (fresh) fill_r <= FW'(1);
          else if (fill_r < FW'(RING_DEPTH)) fill_r <= fill_r + FW'(1);
          scan_cnt_r <= FW'(RING_DEPTH);
          scan_r <= '0;
        end
      end
      if (state_r == S_SCAN) begin
        if (scan_cnt_r != '0) begin
          rd_off_r <= ring_off[scan_r];
          rd_arr_r <= ring_arr[scan_r];
          rd_ok_r <= FW'(scan_r) < fill_r;
          scan_r <= scan_r + PW'(1);
          scan_cnt_r <= scan_cnt_r - FW'(1);
        end
        if (rd_ok_r && in_win && ($signed(rd_off_r) < $signed(best_r)))
          best_r <= rd_off_r;
      end
    end
    if (state_r == S_PER) delta_r <= est;
    if (state_r == S_PWAIT && drsp.done) period_r <= drsp.quot;
    if (state_r == S_DWAIT && drsp.done) begin
      res_r.synced <= valid_r;
      res_r.offset_estimate_us <= best_r;
      if (delta_r[WideW-1]) begin
        res_r.since_beat_us <= PhaseW'((drsp.rem == '0) ? '0 : period_r - drsp.rem);
        res_r.beat_count <= '0;
      end else begin
        res_r.since_beat_us <= PhaseW'(drsp.rem);
        res_r.beat_count <= drsp.quot[TimeW-1:0];
      end
    end
  end

`ifndef ASSERT_OFF
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FW'(RING_DEPTH))
    else $error("ring fill overflow");
  a_valid_ref: assert property (@(posedge clk) disable iff (!rst_n) valid_r |-> have_ref_r)
    else $error("offset valid without reference");
`endif
endmodule

>>> test/tb_beacon_clock_sync_beat_phase.sv
`timescale 1ns / 1ps
module tb_beacon_clock_sync_beat_phase;
  import bcsbp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_wdata = '0;

  bcsbp_if #(.T(in_word_t)) in_ch ();
  bcsbp_if #(.T(out_word_t)) out_ch ();

  beacon_clock_sync_beat_phase u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [LatW-1:0] lat_ms;
  logic [WinW-1:0] win_us;
  logic have_ref;
  logic [WideW-1:0] anchor_q;
  logic [ChanW-1:0] chan_q;
  logic [BpmW-1:0] bpm_q;
  logic off_ok;
  logic [WideW-1:0] off_best;
  logic [WideW-1:0] smp_off [16];
  logic [WideW-1:0] smp_arr [16];
  int smp_fill, smp_pos;

  out_word_t beat_q[$];
  int errors = 0;
  int n_words = 0, n_beacons = 0, n_results = 0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;

  function automatic void sync_reset();
    lat_ms = '0; win_us = WindowReset; have_ref = 0; anchor_q = '0; chan_q = '0;
    bpm_q = '0; off_ok = 0; off_best = '0; smp_fill = 0; smp_pos = 0;
  endfunction

  function automatic void cfg_model(cfg_idx_t idx, logic [CfgW-1:0] v);
    if (idx == CFG_LATENCY) lat_ms = (v[8:0] > LatencyMax) ? LatencyMax : v[8:0];
    else win_us = v;
  endfunction

  function automatic out_word_t beat_predict(in_word_t w);
    out_word_t r;
    logic [WideW-1:0] now, raw, best, age, period, est, dlt, mag;
    now = {1'b0, w.local_time_us};
    if (w.op == OP_BEACON) begin
      if (!have_ref || {1'b0, w.anchor_time_us} != anchor_q || w.channel != chan_q) begin
        smp_fill = 0; smp_pos = 0; off_ok = 0;
        anchor_q = {1'b0, w.anchor_time_us}; chan_q = w.channel; have_ref = 1;
      end
      bpm_q = w.tempo_bpm;
      raw = now - {1'b0, w.sender_time_us};
      smp_off[smp_pos] = raw; smp_arr[smp_pos] = now;
      smp_pos = (smp_pos + 1) % 16;
      if (smp_fill < 16) smp_fill++;
      best = raw;
      for (int i = 0; i < smp_fill; i++) begin
        age = now - smp_arr[i];
        if (!age[63] && age > {32'd0, win_us}) continue;
        if ($signed(smp_off[i]) < $signed(best)) best = smp_off[i];
      end
      off_best = best; off_ok = 1;
    end
    period = PeriodNum / ((bpm_q == 0) ? 64'd1 : {56'd0, bpm_q});
    est = now - off_best - {55'd0, lat_ms} * 64'd1000;
    dlt = est - anchor_q;
    r.synced = off_ok;
    r.offset_estimate_us = off_best;
    if (dlt[63]) begin
      mag = (-dlt) % period;
      r.since_beat_us = PhaseW'((mag != 0) ? period - mag : 64'd0);
      r.beat_count = '0;
    end else begin
      r.since_beat_us = PhaseW'(dlt % period);
      r.beat_count = TimeW'(dlt / period);
    end
    return r;
  endfunction

  task automatic cfg_write(cfg_idx_t idx, logic [CfgW-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_model(idx, v);
  endtask

  task automatic send_word(in_word_t w);
    while (idle_on && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    beat_q.push_back(beat_predict(w));
    n_words++;
    if (w.op == OP_BEACON) n_beacons++;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard = 0;
    in_ch.valid <= 1'b0;
    while (beat_q.size() != 0 && guard < 200000) begin
      @(negedge clk); guard++;
    end
    repeat (400) @(negedge clk);
  endtask

  function automatic logic [62:0] r63();
    return 63'({$urandom, $urandom});
  endfunction

  // receiver
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(idle_on && $urandom_range(99) < 37);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (beat_q.size() == 0) begin
        $error("unexpected result word"); errors++;
      end else begin
        out_word_t e;
        e = beat_q.pop_front();
        if (out_ch.data.synced !== e.synced) begin
          $error("synced exp %0d got %0d", e.synced, out_ch.data.synced); errors++;
        end
        if (out_ch.data.offset_estimate_us !== e.offset_estimate_us) begin
          $error("offset_estimate_us exp %0d got %0d", e.offset_estimate_us,
                 out_ch.data.offset_estimate_us); errors++;
        end
        if (out_ch.data.since_beat_us !== e.since_beat_us) begin
          $error("since_beat_us exp %0d got %0d", e.since_beat_us,
                 out_ch.data.since_beat_us); errors++;
        end
        if (out_ch.data.beat_count !== e.beat_count) begin
          $error("beat_count exp %0d got %0d", e.beat_count, out_ch.data.beat_count); errors++;
        end
      end
    end
  end

  // long receiver stall while sender keeps offering
  initial begin
    wait (n_words == 150);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  typedef struct {
    in_word_t w;
    bit chk;
    out_word_t r;
  } dir_row_t;

  function automatic in_word_t mk(logic op, logic [62:0] lt, logic [62:0] st,
                                  logic [62:0] an, logic [7:0] ch, logic [7:0] bpm);
    in_word_t w;
    w.op = op; w.local_time_us = lt; w.sender_time_us = st;
    w.anchor_time_us = an; w.channel = ch; w.tempo_bpm = bpm;
    return w;
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    logic [62:0] t, an, base;
    logic [7:0] ch, bpm;
    in_word_t e;
    out_word_t pr;
    logic [62:0] ones;
    ones = '1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    sync_reset();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // query before any beacon: period 60e6, anchor 0, offset 0
    row.w = mk(OP_QUERY, 63'd61000000, 63'd0, 63'd0, 8'd0, 8'd0); row.chk = 1;
    row.r = '{synced: 0, offset_estimate_us: 0, since_beat_us: 1000000, beat_count: 1};
    rows.push_back(row);
    row.chk = 0;
    row.w = mk(OP_QUERY, ones, ones, ones, 8'hff, 8'hff); rows.push_back(row);
    row.w = mk(OP_BEACON, 63'd1000, 63'd0, 63'd0, 8'd0, 8'd60); row.chk = 1;
    row.r = '{synced: 1, offset_estimate_us: 1000, since_beat_us: 0, beat_count: 0};
    rows.push_back(row);
    row.chk = 0;
    row.w = mk(OP_BEACON, 63'd2000, 63'd1500, 63'd0, 8'd0, 8'd0); rows.push_back(row);
    row.w = mk(OP_BEACON, 63'd100, 63'd200, 63'd0, 8'd0, 8'd120); rows.push_back(row);
    row.w = mk(OP_BEACON, 63'd0, ones, 63'd0, 8'd0, 8'd255); rows.push_back(row);
    row.w = mk(OP_BEACON, ones, 63'd0, ones, 8'd7, 8'd1); rows.push_back(row);
    row.w = mk(OP_BEACON, ones, ones, ones, 8'd8, 8'd200); rows.push_back(row);
    row.w = mk(OP_QUERY, 63'd0, 63'd0, 63'd0, 8'd0, 8'd0); rows.push_back(row);
    row.w = mk(OP_BEACON, 63'd5, 63'd9, 63'h5555_5555_5555_5555, 8'hAA, 8'h55);
    rows.push_back(row);
    row.w = mk(OP_BEACON, 63'd6, 63'd1, 63'h2AAA_AAAA_AAAA_AAAA, 8'h55, 8'hAA);
    rows.push_back(row);
    for (int i = 0; i < 18; i++) begin   // fill and wrap the ring
      row.w = mk(OP_BEACON, 63'd10000 + 63'(i) * 400000, 63'(i * 37 % 11),
                 63'd77, 8'd3, 8'd90);
      rows.push_back(row);
    end
    foreach (rows[k]) begin
      pr = beat_predict(rows[k].w);
      if (rows[k].chk && pr !== rows[k].r) begin
        $error("directed row %0d: table/predictor disagree", k); errors++;
      end
      // predictor already advanced; send_word re-predicts, so restore is done by replay
    end
    sync_reset();
    foreach (rows[k]) send_word(rows[k].w);
    drain();

    // settings: extremes and middles, incl. window 0 and saturating latency
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_LATENCY, 32'd511); cfg_write(CFG_WINDOW, 32'd0); end
        1: begin cfg_write(CFG_LATENCY, 32'd500); cfg_write(CFG_WINDOW, 32'hffffffff); end
        2: begin cfg_write(CFG_LATENCY, 32'd0); cfg_write(CFG_WINDOW, 32'd1); end
        3: begin cfg_write(CFG_LATENCY, 32'd501); cfg_write(CFG_WINDOW, 32'd300000); end
        default: begin
          cfg_write(CFG_LATENCY, $urandom_range(499)); cfg_write(CFG_WINDOW, 32'd5000000);
        end
      endcase
      idle_on = (ph != 2);
      base = (ph == 1) ? (ones - 63'd100000000) : r63() >> $urandom_range(62);
      t = base; an = r63() >> $urandom_range(62); ch = 8'($urandom); bpm = 8'($urandom);
      for (int i = 0; i < 110; i++) begin
        e = mk($urandom_range(99) < 30 ? OP_QUERY : OP_BEACON, t, 63'd0, an, ch, bpm);
        case ($urandom_range(19))
          0: e.local_time_us = r63();
          1: begin an = r63(); e.anchor_time_us = an; end
          2: begin ch = 8'($urandom); e.channel = ch; end
          3: e.tempo_bpm = 8'($urandom);
          4: e.sender_time_us = r63();
          default: ;
        endcase
        if ($urandom_range(19) != 4)
          e.sender_time_us = e.local_time_us - 63'($urandom_range(20000))
                             + 63'd10000 - 63'($urandom_range(1000));
        if ($urandom_range(9) == 0) e.local_time_us = t - 63'($urandom_range(500000));
        send_word(e);
        t = t + 63'($urandom_range(400000));
      end
      drain();
    end

    $display("Covered %0d words (%0d beacons), %0d results across 6 register settings.",
             n_words, n_beacons, n_results);
    if (errors == 0 && beat_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
